// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on the block clock with the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define CEB_ASSERT_IMPL(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define CEB_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/ceb_pkg.sv =====
// ----------------------------------------------------------------------------
// ceb_pkg
// Shared constants and register codes of the color-erase pixel blend.
// ----------------------------------------------------------------------------
`default_nettype none

package ceb_pkg;
	localparam int CHANNEL_BITS_DEF = 16;
	localparam int CFG_IDX_W        = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPACITY     = 8'd0,
		REG_MASK_ENABLE = 8'd1
	} cfg_reg_t;
endpackage

`default_nettype wire

// ===== rtl/core/ceb_if.sv =====
// ----------------------------------------------------------------------------
// ceb_if
// Valid/ready channels: pixel input, pixel output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ceb_pix_in_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] base_red;
	logic [W-1:0] base_green;
	logic [W-1:0] base_blue;
	logic [W-1:0] base_alpha;
	logic [W-1:0] layer_red;
	logic [W-1:0] layer_green;
	logic [W-1:0] layer_blue;
	logic [W-1:0] layer_alpha_in;
	logic [W-1:0] mask_value;
	logic         last_in_span;

	modport source(output valid, base_red, base_green, base_blue, base_alpha,
		layer_red, layer_green, layer_blue, layer_alpha_in, mask_value,
		last_in_span, input ready);
	modport sink(input valid, base_red, base_green, base_blue, base_alpha,
		layer_red, layer_green, layer_blue, layer_alpha_in, mask_value,
		last_in_span, output ready);
endinterface

interface ceb_pix_out_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] out_red;
	logic [W-1:0] out_green;
	logic [W-1:0] out_blue;
	logic [W-1:0] out_alpha;
	logic         last_out;

	modport source(output valid, out_red, out_green, out_blue, out_alpha, last_out,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_alpha, last_out,
		output ready);
endinterface

interface ceb_cfg_if #(parameter int W = 16);
	import ceb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [W-1:0]         data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/color_erase_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// color_erase_pixel_blend
// Color-erase compositing of an RGBA layer pixel onto an RGBA base pixel.
// ----------------------------------------------------------------------------
// Channels: pix_in carries one base/layer pixel pair per transaction, pix_out
// one blended pixel, cfg writes opacity (index 0) and mask_enable (index 1);
// cfg is always ready; it is to be written only while the pipeline is empty,
// which the block itself does not enforce. Throughput: one pixel per cycle
// while pix_out does not stall. The pipeline holds two pipelined restoring
// dividers of CHANNEL_BITS+2 stages each (erase alpha, un-mix) plus the
// fraction multipliers and alignment stages.
// A stalled pix_out freezes the whole pipeline in place: pix_in.ready follows
// pix_out.ready whenever the output register is full, so nothing is lost or
// repeated. Bubbles travel as invalid stages.
// Reset clears all stage valid bits, sets opacity to full scale and disables
// the mask.
// ----------------------------------------------------------------------------
`default_nettype none

module color_erase_pixel_blend #(
	parameter int CHANNEL_BITS = ceb_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ceb_cfg_if.sink       cfg,
	ceb_pix_in_if.sink    pix_in,
	ceb_pix_out_if.source pix_out
);
	import ceb_pkg::*;

	localparam int          W     = CHANNEL_BITS;
	localparam int          LD    = W + 2;
	localparam int          E     = 1 + LD;
	localparam int          T     = 2 * LD + 7;
	localparam longint      ONE_L = (64'd1 << W) - 64'd1;
	localparam logic [W-1:0] ONE  = '1;
	localparam logic [W-1:0] THR  = W'((ONE_L + 64'd9999) / 64'd10000);
	localparam int          SW    = 7 * W + 1;
	localparam int          S2W   = 7 * W + 5;

	logic         en;
	logic [T:0]   stage_vld_s;
	logic [W-1:0] opacity_q;
	logic         mask_en_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= ONE;
			mask_en_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OPACITY:     opacity_q <= cfg.data;
				REG_MASK_ENABLE: mask_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// global advance: output register empty or being drained
	assign en           = !stage_vld_s[T] || pix_out.ready;
	assign pix_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_s <= '0;
		end else if (en) begin
			stage_vld_s <= {stage_vld_s[T-1:0], pix_in.valid};
		end
	end

	// input stage
	logic [W-1:0] base_s1 [0:3];
	logic [W-1:0] lay_s1  [0:2];
	logic [W-1:0] la_in_s1;
	logic [W-1:0] mask_s1;
	logic         last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1[0] <= pix_in.base_red;
			base_s1[1] <= pix_in.base_green;
			base_s1[2] <= pix_in.base_blue;
			base_s1[3] <= pix_in.base_alpha;
			lay_s1[0]  <= pix_in.layer_red;
			lay_s1[1]  <= pix_in.layer_green;
			lay_s1[2]  <= pix_in.layer_blue;
			la_in_s1   <= pix_in.layer_alpha_in;
			mask_s1    <= pix_in.mask_value;
			last_s1    <= pix_in.last_in_span;
		end
	end

	// layer alpha: opacity, then mask (times ONE is identity when disabled)
	logic [W-1:0] la_op;
	logic [W-1:0] mask_d;
	logic [W-1:0] la;
	logic [W-1:0] la_d1;
	logic [W-1:0] la_d2;

	ceb_mul_frac #(.W(W)) u_mul_op (
		.clk(clk), .en(en), .a(la_in_s1), .b(opacity_q), .y(la_op)
	);

	ceb_delay #(.W(W), .DEPTH(2)) u_dly_mask (
		.clk(clk), .en(en), .d(mask_s1), .q(mask_d)
	);

	ceb_mul_frac #(.W(W)) u_mul_mask (
		.clk(clk), .en(en), .a(la_op), .b(mask_en_q ? mask_d : ONE), .y(la)
	);

	ceb_delay #(.W(W), .DEPTH(W)) u_dly_la1 (
		.clk(clk), .en(en), .d(la), .q(la_d1)
	);

	ceb_delay #(.W(W), .DEPTH(2)) u_dly_la2 (
		.clk(clk), .en(en), .d(la_d1), .q(la_d2)
	);

	// erase alpha per channel
	logic [W-1:0] ers [0:2];
	logic [W:0]   ers_quo [0:2];
	logic         ers_div [0:2];

	for (genvar c = 0; c < 3; c++) begin : g_erase
		logic [W-1:0]   diff;
		logic [2*W-1:0] num_s2;
		logic [W-1:0]   den_s2;
		logic           selc_s2;
		logic           zero_s2;
		logic [W-1:0]   c_s2;
		logic [W+1:0]   flg_d;

		assign diff = (base_s1[c] > lay_s1[c]) ? base_s1[c] - lay_s1[c]
			: lay_s1[c] - base_s1[c];

		always_ff @(posedge clk) begin
			if (en) begin
				num_s2  <= {diff, W'(0)} - (2*W)'(diff);
				den_s2  <= (base_s1[c] > lay_s1[c]) ? ONE - lay_s1[c] : lay_s1[c];
				selc_s2 <= lay_s1[c] < THR;
				zero_s2 <= base_s1[c] == lay_s1[c];
				c_s2    <= base_s1[c];
			end
		end

		ceb_div_round #(.W(W)) u_div (
			.clk(clk), .en(en), .num(num_s2), .den(den_s2), .quo(ers_quo[c])
		);

		ceb_delay #(.W(W+2), .DEPTH(LD)) u_dly_flg (
			.clk(clk), .en(en), .d({selc_s2, zero_s2, c_s2}), .q(flg_d)
		);

		assign ers_div[c] = !flg_d[W+1] && !flg_d[W];
		assign ers[c]     = flg_d[W+1] ? flg_d[W-1:0]
			: flg_d[W] ? '0 : ers_quo[c][W-1:0];
	end

	logic [W-1:0] m_s3;
	logic [W-1:0] m01;

	assign m01 = (ers[1] > ers[0]) ? ers[1] : ers[0];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= (ers[2] > m01) ? ers[2] : m01;
		end
	end

	// new alpha
	logic [W-1:0] mla;
	logic [W:0]   na_sum;
	logic [W-1:0] na_s4;

	ceb_mul_frac #(.W(W)) u_mul_na (
		.clk(clk), .en(en), .a(m_s3), .b(la_d1), .y(mla)
	);

	assign na_sum = (W+1)'(ONE - la_d2) + (W+1)'(mla);

	always_ff @(posedge clk) begin
		if (en) begin
			na_s4 <= na_sum[W] ? ONE : na_sum[W-1:0];
		end
	end

	// side data from the input stage to the new-alpha stage
	logic [SW-1:0] side_d;
	logic [W-1:0]  sb [0:3];
	logic [W-1:0]  sl [0:2];
	logic          slast;

	ceb_delay #(.W(SW), .DEPTH(E+4)) u_dly_side (
		.clk(clk), .en(en),
		.d({base_s1[0], base_s1[1], base_s1[2], base_s1[3],
			lay_s1[0], lay_s1[1], lay_s1[2], last_s1}),
		.q(side_d)
	);

	assign {sb[0], sb[1], sb[2], sb[3], sl[0], sl[1], sl[2], slast} = side_d;

	// un-mix toward the layer color
	logic         na_ok;
	logic [2:0]   ge;
	logic [W:0]   um_quo [0:2];
	logic [W-1:0] alpha_mul;
	logic [W-1:0] alpha_d;
	logic [S2W-1:0] side2_d;
	logic [W-1:0] fb [0:2];
	logic [W-1:0] fl [0:2];
	logic [2:0]   fge;
	logic         fok;
	logic [W-1:0] fna;
	logic         flast;
	logic [W-1:0] col [0:2];

	assign na_ok = na_s4 >= THR;

	for (genvar c = 0; c < 3; c++) begin : g_unmix
		logic [W-1:0]   diff;
		logic [2*W-1:0] num_s5;
		logic [W-1:0]   den_s5;
		logic [W+1:0]   up;

		assign ge[c] = sb[c] >= sl[c];
		assign diff  = ge[c] ? sb[c] - sl[c] : sl[c] - sb[c];

		always_ff @(posedge clk) begin
			if (en) begin
				num_s5 <= {diff, W'(0)} - (2*W)'(diff);
				den_s5 <= na_s4;
			end
		end

		ceb_div_round #(.W(W)) u_div (
			.clk(clk), .en(en), .num(num_s5), .den(den_s5), .quo(um_quo[c])
		);

		assign up = (W+2)'(um_quo[c]) + (W+2)'(fl[c]);

		always_comb begin
			if (!fok) begin
				col[c] = fb[c];
			end else if (fge[c]) begin
				col[c] = (up > (W+2)'(ONE)) ? ONE : up[W-1:0];
			end else begin
				col[c] = (um_quo[c] >= (W+1)'(fl[c])) ? '0 : fl[c] - um_quo[c][W-1:0];
			end
		end
	end

	ceb_mul_frac #(.W(W)) u_mul_alpha (
		.clk(clk), .en(en), .a(na_s4), .b(sb[3]), .y(alpha_mul)
	);

	ceb_delay #(.W(W), .DEPTH(LD-1)) u_dly_alpha (
		.clk(clk), .en(en), .d(alpha_mul), .q(alpha_d)
	);

	ceb_delay #(.W(S2W), .DEPTH(LD+1)) u_dly_side2 (
		.clk(clk), .en(en),
		.d({sb[0], sb[1], sb[2], sl[0], sl[1], sl[2], ge, na_ok, na_s4, slast}),
		.q(side2_d)
	);

	assign {fb[0], fb[1], fb[2], fl[0], fl[1], fl[2], fge, fok, fna, flast} = side2_d;

	// output register
	logic [W-1:0] red_q;
	logic [W-1:0] green_q;
	logic [W-1:0] blue_q;
	logic [W-1:0] alpha_q;
	logic         last_q;
	logic         ok_q;

	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= col[0];
			green_q <= col[1];
			blue_q  <= col[2];
			alpha_q <= fok ? alpha_d : fna;
			last_q  <= flast;
			ok_q    <= fok;
		end
	end

	assign pix_out.valid     = stage_vld_s[T];
	assign pix_out.out_red   = red_q;
	assign pix_out.out_green = green_q;
	assign pix_out.out_blue  = blue_q;
	assign pix_out.out_alpha = alpha_q;
	assign pix_out.last_out  = last_q;

	`include "assert_macros.svh"

	// a divided erase alpha never exceeds full scale
	`CEB_ASSERT_IMPL(a_ers_r, stage_vld_s[E] && ers_div[0], ers_quo[0] <= (W+1)'(ONE))
	`CEB_ASSERT_IMPL(a_ers_g, stage_vld_s[E] && ers_div[1], ers_quo[1] <= (W+1)'(ONE))
	`CEB_ASSERT_IMPL(a_ers_b, stage_vld_s[E] && ers_div[2], ers_quo[2] <= (W+1)'(ONE))
	// pass-through pixels carry a new alpha below the threshold
	`CEB_ASSERT_IMPL(a_pass, stage_vld_s[T] && !ok_q, alpha_q < THR)
endmodule

`default_nettype wire

// ===== rtl/core/ceb_delay.sv =====
// ----------------------------------------------------------------------------
// ceb_delay
// Stallable delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_delay #(
	parameter int W     = 16,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] tap_s [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];
endmodule

`default_nettype wire

// ===== rtl/core/ceb_mul_frac.sv =====
// ----------------------------------------------------------------------------
// ceb_mul_frac
// Fraction product a*b/ONE, rounded to nearest, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_mul_frac #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] y
);
	localparam logic [W-1:0] HALF = {1'b0, {(W-1){1'b1}}};

	logic [2*W-1:0] x_s1;
	logic [2*W:0]   t;
	logic [2*W:0]   sum;
	logic [W-1:0]   y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= (2*W)'(a) * (2*W)'(b) + (2*W)'(HALF);
		end
	end

	// x / (2^W - 1) without a divider: t = x + 1, q = (t + t>>W) >> W
	assign t   = {1'b0, x_s1} + (2*W+1)'(1);
	assign sum = t + (t >> W);

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= sum[2*W-1:W];
		end
	end

	assign y = y_s2;
endmodule

`default_nettype wire

// ===== rtl/core/ceb_div_round.sv =====
// ----------------------------------------------------------------------------
// ceb_div_round
// Pipelined restoring divider, rounded quotient, clamped to W+1 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_div_round #(
	parameter int W = 16
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [2*W-1:0] num,
	input  wire logic [W-1:0]   den,
	output logic      [W:0]     quo
);
	localparam int QW = W + 1;

	logic [2*W-1:0] n;
	logic [W-1:0]   r_s   [0:QW-1];
	logic [QW-1:0]  lo_s  [0:QW-1];
	logic [QW-1:0]  q_s   [0:QW];
	logic [W-1:0]   dv_s  [0:QW];
	logic           sat_s [0:QW];

	// round half up by adding den/2 up front
	assign n = num + (2*W)'(den >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= W'(n[2*W-1:QW]);
			lo_s[0]  <= n[QW-1:0];
			q_s[0]   <= '0;
			dv_s[0]  <= den;
			sat_s[0] <= W'(n[2*W-1:QW]) >= den;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [W:0] t;
		logic       ge;

		assign t  = {r_s[k], lo_s[k][QW-1]};
		assign ge = t >= {1'b0, dv_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= {q_s[k][QW-2:0], ge};
				dv_s[k+1]  <= dv_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k+1]  <= ge ? W'(t - {1'b0, dv_s[k]}) : W'(t);
					lo_s[k+1] <= {lo_s[k][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = sat_s[QW] ? '1 : q_s[QW];
endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the color-erase pixel blend.
// ----------------------------------------------------------------------------
// Pixels go in on pix_in and come back on pix_out. A model of the blend
// computes each expected pixel at input acceptance and queues it. Every output
// transaction is compared against the head of that queue. A directed table
// runs first, then random pixels under several register settings, with random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ceb_pkg::*;

	localparam int          W         = 16;
	localparam logic [31:0] ONE       = 32'd65535;
	localparam logic [31:0] THR       = (ONE + 32'd9999) / 32'd10000;
	localparam int          LATENCY   = 2 * W + 11;
	localparam int          WDOG_MAX  = 20000;
	localparam int          N_RANDOM  = 360;

	typedef struct packed {
		logic [W-1:0] br, bg, bb, ba, lr, lg, lb, la, mk;
		logic         last;
	} pixel_in_t;

	typedef struct packed {
		logic [W-1:0] r, g, b, a;
		logic         last;
	} pixel_out_t;

	typedef struct {
		pixel_in_t  px;
		bit         known;
		pixel_out_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ceb_cfg_if    #(W) cfg();
	ceb_pix_in_if  #(W) pix_in();
	ceb_pix_out_if #(W) pix_out();

	color_erase_pixel_blend #(.CHANNEL_BITS(W)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .pix_in(pix_in.sink),
		.pix_out(pix_out.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [W-1:0] opacity_q = W'(ONE);
	bit           mask_en_q = 1'b0;

	pixel_out_t expected_px[$];
	int         n_errors = 0;
	int         n_in = 0;
	int         n_out = 0;
	int         idle_cycles = 0;
	bit         no_idle = 1'b0;
	bit         out_hold = 1'b0;
	bit         stim_done = 1'b0;

	function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
		return (a * b + ONE / 2) / ONE;
	endfunction

	function automatic logic [63:0] rdiv(logic [63:0] n, logic [63:0] d);
		if (d == 0)
			return 0;
		return (n + d / 2) / d;
	endfunction

	function automatic logic [63:0] erase_of(logic [63:0] c, logic [63:0] l);
		if (l < THR)
			return c;
		if (c > l)
			return rdiv((c - l) * ONE, ONE - l);
		if (c < l)
			return rdiv((l - c) * ONE, l);
		return 0;
	endfunction

	function automatic logic [W-1:0] unpremul(logic [63:0] c, logic [63:0] l,
			logic [63:0] na);
		logic [63:0] q;
		if (c >= l) begin
			q = rdiv((c - l) * ONE, na) + l;
			return (q > ONE) ? W'(ONE) : W'(q);
		end
		q = rdiv((l - c) * ONE, na);
		return (q >= l) ? W'(0) : W'(l - q);
	endfunction

	function automatic pixel_out_t blend_pixel(pixel_in_t p);
		pixel_out_t  o;
		logic [63:0] la, mx, e, na;
		logic [63:0] c[3];
		logic [63:0] l[3];
		c = '{p.br, p.bg, p.bb};
		l = '{p.lr, p.lg, p.lb};
		la = frac_mul(p.la, opacity_q);
		if (mask_en_q)
			la = frac_mul(la, p.mk);
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			e = erase_of(c[i], l[i]);
			if (e > mx)
				mx = e;
		end
		na = (ONE - la) + frac_mul(mx, la);
		if (na > ONE)
			na = ONE;
		if (na >= THR) begin
			o.r = unpremul(c[0], l[0], na);
			o.g = unpremul(c[1], l[1], na);
			o.b = unpremul(c[2], l[2], na);
			o.a = W'(frac_mul(na, p.ba));
		end else begin
			o.r = p.br;
			o.g = p.bg;
			o.b = p.bb;
			o.a = W'(na);
		end
		o.last = p.last;
		return o;
	endfunction

	function automatic logic [W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return W'($urandom_range(0, 8));
			1: return W'(65535 - $urandom_range(0, 8));
			default: return W'($urandom);
		endcase
	endfunction

	function automatic pixel_in_t rand_pixel();
		pixel_in_t p;
		p = pixel_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		p.br = rand_chan(); p.bg = rand_chan(); p.bb = rand_chan();
		p.ba = rand_chan(); p.lr = rand_chan(); p.lg = rand_chan();
		p.lb = rand_chan(); p.la = rand_chan(); p.mk = rand_chan();
		// base equal to layer on the green channel
		if ($urandom_range(0, 5) == 0)
			p.bg = p.lg;
		// nearly erased pixel: new alpha below threshold at full opacity, mask off
		if ($urandom_range(0, 7) == 0) begin
			p.br = p.lr; p.bg = p.lg; p.bb = p.lb;
			p.la = W'(ONE);
		end
		return p;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_OPACITY)
			opacity_q = val;
		else if (idx == REG_MASK_ENABLE)
			mask_en_q = val[0];
	endtask

	task automatic drain();
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Drives one pixel; valid stays high across back-to-back transactions.
	task automatic send_pixel(pixel_in_t p);
		while (!no_idle && $urandom_range(0, 99) < 13) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid          <= 1'b1;
		pix_in.base_red       <= p.br;
		pix_in.base_green     <= p.bg;
		pix_in.base_blue      <= p.bb;
		pix_in.base_alpha     <= p.ba;
		pix_in.layer_red      <= p.lr;
		pix_in.layer_green    <= p.lg;
		pix_in.layer_blue     <= p.lb;
		pix_in.layer_alpha_in <= p.la;
		pix_in.mask_value     <= p.mk;
		pix_in.last_in_span   <= p.last;
		do @(posedge clk); while (!pix_in.ready);
		expected_px.push_back(blend_pixel(p));
		n_in++;
	endtask

	task automatic idle_in();
		pix_in.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_pixel(rand_pixel());
		idle_in();
	endtask

	task automatic check_pixel(pixel_out_t got);
		pixel_out_t want;
		if (expected_px.size() == 0) begin
			n_errors++;
			if (n_errors <= 10)
				$display("ERROR: unexpected output pixel %h", got);
			return;
		end
		want = expected_px.pop_front();
		if (got !== want) begin
			n_errors++;
			if (n_errors <= 10)
				$display("ERROR: pixel %0d exp r=%h g=%h b=%h a=%h l=%b got r=%h g=%h b=%h a=%h l=%b",
					n_out, want.r, want.g, want.b, want.a, want.last,
					got.r, got.g, got.b, got.a, got.last);
		end
	endtask

	// Output side: random ready, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				check_pixel('{pix_out.out_red, pix_out.out_green, pix_out.out_blue,
					pix_out.out_alpha, pix_out.last_out});
				n_out++;
			end
			pix_out.ready <= !out_hold && (no_idle || $urandom_range(0, 99) >= 13);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
				|| (cfg.valid && cfg.ready) || !arst_n || out_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	task automatic add_row(pixel_in_t p, bit known, pixel_out_t r);
		dir_row_t d;
		d.px = p; d.known = known; d.res = r;
		dir_rows.push_back(d);
	endtask

	initial begin
		pixel_in_t z, f;
		pix_in.valid = 1'b0;
		pix_in.base_red = '0; pix_in.base_green = '0; pix_in.base_blue = '0;
		pix_in.base_alpha = '0; pix_in.layer_red = '0; pix_in.layer_green = '0;
		pix_in.layer_blue = '0; pix_in.layer_alpha_in = '0; pix_in.mask_value = '0;
		pix_in.last_in_span = 1'b0;
		cfg.valid = 1'b0; cfg.index = REG_OPACITY; cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z = '0;
		f = '1;
		// transparent layer: colors kept, alpha scaled by base alpha
		add_row(z, 1, '{16'h0, 16'h0, 16'h0, 16'h0, 1'b0});
		// opaque white layer over white base: fully erased, colors pass
		add_row(f, 1, '{16'hffff, 16'hffff, 16'hffff, 16'h0, 1'b1});
		z.ba = 16'hffff; z.la = 16'hffff; z.last = 1'b1;
		// black layer below threshold: erase alpha is the base value (0)
		add_row(z, 1, '{16'h0, 16'h0, 16'h0, 16'h0, 1'b1});
		z.br = 16'hffff;
		add_row(z, 1, '{16'hffff, 16'h0, 16'h0, 16'hffff, 1'b1});
		for (int i = 0; i < 14; i++)
			add_row(rand_pixel(), 0, '0);
		add_row('{16'h1234, 16'h8000, 16'hfff0, 16'h8000, 16'h0007, 16'h0006,
			16'hffff, 16'h8000, 16'h4000, 1'b0}, 0, '0);
		add_row('{16'h0000, 16'hffff, 16'h0007, 16'hffff, 16'hffff, 16'h0000,
			16'h0008, 16'hffff, 16'hffff, 1'b1}, 0, '0);

		foreach (dir_rows[i]) begin
			send_pixel(dir_rows[i].px);
			if (dir_rows[i].known)
				expected_px[$] = dir_rows[i].res;
		end
		idle_in();
		drain();

		run_random(N_RANDOM / 2);
		// long output stall while input keeps offering
		fork
			begin
				out_hold = 1'b1;
				repeat (3 * LATENCY) @(posedge clk);
				out_hold = 1'b0;
			end
			run_random(120);
		join
		drain();

		write_reg(REG_MASK_ENABLE, 16'h1);
		write_reg(REG_OPACITY, 16'h0);
		run_random(60);
		drain();
		write_reg(REG_OPACITY, 16'h8000);
		no_idle = 1'b1;
		run_random(150);
		no_idle = 1'b0;
		drain();
		write_reg(REG_MASK_ENABLE, 16'h0);
		write_reg(REG_OPACITY, 16'h3a5c);
		run_random(N_RANDOM / 2);
		drain();
		write_reg(REG_OPACITY, 16'hffff);
		run_random(40);
		drain();
		stim_done = 1'b1;

		$display("Covered %0d pixels in, %0d out, over opacity 0/half/odd/full, mask on and off.",
			n_in, n_out);
		$display("Errors: %0d, pixels still pending: %0d", n_errors, expected_px.size());
		if (n_errors == 0 && expected_px.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

`default_nettype wire

// ===== color_erase_pixel_blend.f =====
+incdir+rtl/core
rtl/core/ceb_pkg.sv
rtl/core/ceb_if.sv
rtl/core/ceb_delay.sv
rtl/core/ceb_mul_frac.sv
rtl/core/ceb_div_round.sv
rtl/core/color_erase_pixel_blend.sv
tb/sv/tb.sv
